/* rtl/core/mfb_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the frame blend pipeline
// no dependencies; imported by every module of the block

package mfb_pkg;

  // blend modes as held after a configuration write (unused code folds to regular)
  typedef enum logic [1:0] {
    MODE_SIMPLE  = 2'd0,
    MODE_REGULAR = 2'd1,
    MODE_EXTRA   = 2'd2
  } mode_t;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 2;
  localparam logic [1:0]  CFG_BLEND_MODE   = 2'd0;
  localparam logic [1:0]  CFG_TIME_WEIGHT  = 2'd1;
  localparam logic [1:0]  CFG_WIDE_SAMPLES = 2'd2;
  localparam int          CFG_W            = 9;

  // field widths
  localparam int IN_W        = 16;
  localparam int OUT_W       = 16;
  localparam int MASK_W      = 8;
  localparam int TW_W        = 9;
  localparam int NARROW_BITS = 8;

  localparam logic [MASK_W-1:0]      MASK_MAX  = 8'd255;
  localparam logic [7:0]             ROUND     = 8'd255;
  localparam logic [NARROW_BITS-1:0] NARROW_MAX = 8'hFF;
  localparam logic [TW_W-1:0]        TW_MAX    = 9'd256;
  localparam logic [TW_W-1:0]        TW_HALF   = 9'd128;

  // register stages from input transfer to output register
  localparam int PIPE_DEPTH = 7;

  // per-item control that travels down the pipe with the data
  typedef struct packed {
    mode_t           mode;
    logic            wide;
    logic            half;
    logic [TW_W-1:0] tw;
  } ctrl_t;

endpackage

/* rtl/core/motion_flow_frame_blend.sv */
`timescale 1ns / 1ps
// top level of the motion-compensated frame blend: config registers and pipe
// depends on mfb_pkg, mfb_front, mfb_mix, mfb_out

// usage
//   pix channel (pix_valid/pix_ready) carries one pixel's prefetched samples and
//   occlusion masks per transfer; blend channel (blend_valid/blend_ready) returns
//   one blended_pixel per input transfer, in order
//   cfg channel writes blend_mode (index 0), time_weight (1), wide_samples (2);
//   cfg_ready is always high, writes are expected only while the pipe is empty
// pipe: seven register stages from input transfer to blend_valid
//   (select/median, weight products, inner sums, nested mask product, flow
//   values, time weighting, clamp into the output register)
// throughput: one pixel per cycle; each stage is elastic, so a bubble anywhere
//   is squeezed out and pix_ready only drops once every stage holds an item
//   and the receiver is stalling
// reset: pipe empties, blend_mode regular, time_weight half, 8-bit samples
// receiver stall: items stay in their stages with payload unchanged; nothing
//   is dropped or repeated

module motion_flow_frame_blend #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input pixel channel
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [mfb_pkg::IN_W-1:0]      fwd_moved,
  input  logic [mfb_pkg::IN_W-1:0]      bwd_moved,
  input  logic [mfb_pkg::IN_W-1:0]      fwd_still,
  input  logic [mfb_pkg::IN_W-1:0]      bwd_still,
  input  logic [mfb_pkg::IN_W-1:0]      fwd_second,
  input  logic [mfb_pkg::IN_W-1:0]      bwd_second,
  input  logic [mfb_pkg::MASK_W-1:0]    fwd_occlusion,
  input  logic [mfb_pkg::MASK_W-1:0]    bwd_occlusion,
  // output pixel channel
  output logic                          blend_valid,
  input  logic                          blend_ready,
  output logic [mfb_pkg::OUT_W-1:0]     blended_pixel,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfb_pkg::CFG_W-1:0]     cfg_data
);
  import mfb_pkg::*;

  localparam int SB = SAMPLE_BITS;

  // unused mode code behaves as regular, so fold it at write time
  function automatic mode_t mode_decode(input logic [1:0] code);
    mode_t m;
    case (code)
      MODE_SIMPLE: m = MODE_SIMPLE;
      MODE_EXTRA:  m = MODE_EXTRA;
      default:     m = MODE_REGULAR;
    endcase
    return m;
  endfunction

  // configuration registers
  mode_t           blend_mode;
  logic [TW_W-1:0] time_weight;
  logic            wide_samples;

  ctrl_t ctrl;

  // front to mix
  logic              fm_valid, fm_ready;
  ctrl_t             fm_ctrl;
  logic [SB+7:0]     fm_prod_fwd, fm_prod_bwd;
  logic [SB+8:0]     fm_term_fwd, fm_term_bwd;
  logic [MASK_W-1:0] fm_occ_fwd, fm_occ_bwd;
  logic [SB:0]       fm_half;

  // mix to out
  logic          mo_valid, mo_ready;
  ctrl_t         mo_ctrl;
  logic [SB+1:0] mo_flow_fwd, mo_flow_bwd;
  logic [SB:0]   mo_half;

  assign cfg_ready = 1'b1;

  // time weight saturates at a full frame step
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= MODE_REGULAR;
      time_weight  <= TW_HALF;
      wide_samples <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLEND_MODE:   blend_mode   <= mode_decode(cfg_data[1:0]);
        CFG_TIME_WEIGHT:  time_weight  <= (cfg_data > TW_MAX) ? TW_MAX : cfg_data;
        CFG_WIDE_SAMPLES: wide_samples <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control word tagged onto each pixel as it enters
  always_comb begin
    ctrl.mode = blend_mode;
    ctrl.wide = wide_samples;
    ctrl.tw   = time_weight;
    // simple mode at exact half time uses the symmetric formula
    ctrl.half = (blend_mode == MODE_SIMPLE) && (time_weight == TW_HALF);
  end

  mfb_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (pix_valid),
    .up_ready     (pix_ready),
    .up_ctrl      (ctrl),
    .fwd_moved    (fwd_moved),
    .bwd_moved    (bwd_moved),
    .fwd_still    (fwd_still),
    .bwd_still    (bwd_still),
    .fwd_second   (fwd_second),
    .bwd_second   (bwd_second),
    .fwd_occlusion(fwd_occlusion),
    .bwd_occlusion(bwd_occlusion),
    .dn_valid     (fm_valid),
    .dn_ready     (fm_ready),
    .dn_ctrl      (fm_ctrl),
    .prod_fwd     (fm_prod_fwd),
    .prod_bwd     (fm_prod_bwd),
    .term_fwd     (fm_term_fwd),
    .term_bwd     (fm_term_bwd),
    .occ_fwd      (fm_occ_fwd),
    .occ_bwd      (fm_occ_bwd),
    .half_res     (fm_half)
  );

  mfb_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk     (clk),
    .rst     (rst),
    .up_valid(fm_valid),
    .up_ready(fm_ready),
    .up_ctrl (fm_ctrl),
    .prod_fwd(fm_prod_fwd),
    .prod_bwd(fm_prod_bwd),
    .term_fwd(fm_term_fwd),
    .term_bwd(fm_term_bwd),
    .occ_fwd (fm_occ_fwd),
    .occ_bwd (fm_occ_bwd),
    .half_res(fm_half),
    .dn_valid(mo_valid),
    .dn_ready(mo_ready),
    .dn_ctrl (mo_ctrl),
    .flow_fwd(mo_flow_fwd),
    .flow_bwd(mo_flow_bwd),
    .dn_half (mo_half)
  );

  mfb_out #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (mo_valid),
    .up_ready     (mo_ready),
    .up_ctrl      (mo_ctrl),
    .flow_fwd     (mo_flow_fwd),
    .flow_bwd     (mo_flow_bwd),
    .half_res     (mo_half),
    .dn_valid     (blend_valid),
    .dn_ready     (blend_ready),
    .blended_pixel(blended_pixel)
  );

endmodule

/* rtl/core/mfb_front.sv */
`timescale 1ns / 1ps
// front of the blend pipe: sample select and median, weight products, inner sums
// stages 1 to 3; depends on mfb_pkg

module mfb_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  mfb_pkg::ctrl_t             up_ctrl,
  input  logic [mfb_pkg::IN_W-1:0]   fwd_moved,
  input  logic [mfb_pkg::IN_W-1:0]   bwd_moved,
  input  logic [mfb_pkg::IN_W-1:0]   fwd_still,
  input  logic [mfb_pkg::IN_W-1:0]   bwd_still,
  input  logic [mfb_pkg::IN_W-1:0]   fwd_second,
  input  logic [mfb_pkg::IN_W-1:0]   bwd_second,
  input  logic [mfb_pkg::MASK_W-1:0] fwd_occlusion,
  input  logic [mfb_pkg::MASK_W-1:0] bwd_occlusion,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output mfb_pkg::ctrl_t             dn_ctrl,
  output logic [SAMPLE_BITS+7:0]     prod_fwd,
  output logic [SAMPLE_BITS+7:0]     prod_bwd,
  output logic [SAMPLE_BITS+8:0]     term_fwd,
  output logic [SAMPLE_BITS+8:0]     term_bwd,
  output logic [mfb_pkg::MASK_W-1:0] occ_fwd,
  output logic [mfb_pkg::MASK_W-1:0] occ_bwd,
  output logic [SAMPLE_BITS:0]       half_res
);
  import mfb_pkg::*;

  localparam int SB = SAMPLE_BITS;

  function automatic logic [SB-1:0] take(input logic [IN_W-1:0] x, input logic wide);
    return wide ? x[SB-1:0] : SB'(x[NARROW_BITS-1:0]);
  endfunction

  function automatic logic [SB-1:0] min2(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [SB-1:0] max2(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic en1, en2, en3;

  // stage 1 comb
  logic [SB-1:0] fm, bm, fs, bs, f2, b2, lo, hi, med_f, med_b, sel_f, sel_b;

  // stage 1 registers
  logic              s1_valid;
  ctrl_t             s1_ctrl;
  logic [SB-1:0]     s1_fm, s1_bm, s1_xf, s1_xb;
  logic [MASK_W-1:0] s1_mf, s1_mb;

  // stage 2 comb and registers
  logic                 reg2;
  logic [MASK_W-1:0]    wf, wb;
  logic signed [SB:0]   dv;
  logic signed [8:0]    dm;
  logic                 s2_valid;
  ctrl_t                s2_ctrl;
  logic [SB+7:0]        s2_pf, s2_pb, s2_af, s2_ab;
  logic [MASK_W-1:0]    s2_mf, s2_mb;
  logic [SB+8:0]        s2_hsum;
  logic signed [SB+9:0] s2_hprod;

  // stage 3 comb
  logic                  reg3;
  logic signed [SB+10:0] hv;

  assign en3      = !dn_valid || dn_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign up_ready = en1;

  always_comb begin
    fm    = take(fwd_moved, up_ctrl.wide);
    bm    = take(bwd_moved, up_ctrl.wide);
    fs    = take(fwd_still, up_ctrl.wide);
    bs    = take(bwd_still, up_ctrl.wide);
    f2    = take(fwd_second, up_ctrl.wide);
    b2    = take(bwd_second, up_ctrl.wide);
    lo    = min2(fm, bm);
    hi    = max2(fm, bm);
    med_b = max2(lo, min2(hi, b2));
    med_f = max2(lo, min2(hi, f2));
    case (up_ctrl.mode)
      MODE_SIMPLE: begin
        sel_f = bm;
        sel_b = fm;
      end
      MODE_EXTRA: begin
        sel_f = med_b;
        sel_b = med_f;
      end
      default: begin
        sel_f = fs;
        sel_b = bs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= up_valid;
    end
    if (en1) begin
      s1_ctrl <= up_ctrl;
      s1_fm   <= fm;
      s1_bm   <= bm;
      s1_xf   <= sel_f;
      s1_xb   <= sel_b;
      s1_mf   <= fwd_occlusion;
      s1_mb   <= bwd_occlusion;
    end
  end

  // regular mode crosses the mask weights on the co-located terms
  assign reg2 = (s1_ctrl.mode == MODE_REGULAR);
  assign wf   = reg2 ? s1_mb : s1_mf;
  assign wb   = reg2 ? s1_mf : s1_mb;
  assign dv   = $signed({1'b0, s1_bm}) - $signed({1'b0, s1_fm});
  assign dm   = $signed({1'b0, s1_mf}) - $signed({1'b0, s1_mb});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
    if (en2) begin
      s2_ctrl  <= s1_ctrl;
      s2_pf    <= (SB+8)'(s1_fm) * (SB+8)'(MASK_MAX - s1_mf);
      s2_pb    <= (SB+8)'(s1_bm) * (SB+8)'(MASK_MAX - s1_mb);
      s2_af    <= (SB+8)'(s1_xf) * (SB+8)'(wf);
      s2_ab    <= (SB+8)'(s1_xb) * (SB+8)'(wb);
      s2_mf    <= s1_mf;
      s2_mb    <= s1_mb;
      s2_hsum  <= {(SB+1)'(s1_fm) + (SB+1)'(s1_bm), 8'd0};
      s2_hprod <= dv * dm;
    end
  end

  assign reg3 = (s2_ctrl.mode == MODE_REGULAR);
  assign hv   = $signed({2'b00, s2_hsum}) + s2_hprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en3) begin
      dn_valid <= s2_valid;
    end
    if (en3) begin
      dn_ctrl  <= s2_ctrl;
      prod_fwd <= s2_pf;
      prod_bwd <= s2_pb;
      term_fwd <= reg3 ? (SB+9)'(s2_pb) + (SB+9)'(s2_af) : (SB+9)'(s2_af);
      term_bwd <= reg3 ? (SB+9)'(s2_pf) + (SB+9)'(s2_ab) : (SB+9)'(s2_ab);
      occ_fwd  <= s2_mf;
      occ_bwd  <= s2_mb;
      half_res <= hv[SB+10] ? '0 : hv[SB+9:9];
    end
  end

endmodule

/* rtl/core/mfb_mix.sv */
`timescale 1ns / 1ps
// middle of the blend pipe: nested mask product and per-direction flow values
// stages 4 and 5; depends on mfb_pkg

module mfb_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  mfb_pkg::ctrl_t             up_ctrl,
  input  logic [SAMPLE_BITS+7:0]     prod_fwd,
  input  logic [SAMPLE_BITS+7:0]     prod_bwd,
  input  logic [SAMPLE_BITS+8:0]     term_fwd,
  input  logic [SAMPLE_BITS+8:0]     term_bwd,
  input  logic [mfb_pkg::MASK_W-1:0] occ_fwd,
  input  logic [mfb_pkg::MASK_W-1:0] occ_bwd,
  input  logic [SAMPLE_BITS:0]       half_res,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output mfb_pkg::ctrl_t             dn_ctrl,
  output logic [SAMPLE_BITS+1:0]     flow_fwd,
  output logic [SAMPLE_BITS+1:0]     flow_bwd,
  output logic [SAMPLE_BITS:0]       dn_half
);
  import mfb_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic en4, en5;
  logic reg4, reg5;

  logic              s4_valid;
  ctrl_t             s4_ctrl;
  logic [SB+7:0]     s4_pf, s4_pb;
  logic [SB+16:0]    s4_qf, s4_qb;
  logic [SB:0]       s4_half;

  logic [SB+16:0] qr_f, qr_b;
  logic [SB+8:0]  x_f, x_b;
  logic [SB+9:0]  sum_f, sum_b;

  assign en5      = !dn_valid || dn_ready;
  assign en4      = !s4_valid || en5;
  assign up_ready = en4;

  assign reg4 = (up_ctrl.mode == MODE_REGULAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en4) begin
      s4_valid <= up_valid;
    end
    if (en4) begin
      s4_ctrl <= up_ctrl;
      s4_pf   <= prod_fwd;
      s4_pb   <= prod_bwd;
      s4_qf   <= reg4 ? (SB+17)'(occ_fwd) * (SB+17)'(term_fwd) : (SB+17)'(term_fwd);
      s4_qb   <= reg4 ? (SB+17)'(occ_bwd) * (SB+17)'(term_bwd) : (SB+17)'(term_bwd);
      s4_half <= half_res;
    end
  end

  // regular mode rounds the nested term down by 8 bits first
  assign reg5  = (s4_ctrl.mode == MODE_REGULAR);
  assign qr_f  = s4_qf + (SB+17)'(ROUND);
  assign qr_b  = s4_qb + (SB+17)'(ROUND);
  assign x_f   = reg5 ? qr_f[SB+16:8] : s4_qf[SB+8:0];
  assign x_b   = reg5 ? qr_b[SB+16:8] : s4_qb[SB+8:0];
  assign sum_f = (SB+10)'(s4_pf) + (SB+10)'(x_f) + (SB+10)'(ROUND);
  assign sum_b = (SB+10)'(s4_pb) + (SB+10)'(x_b) + (SB+10)'(ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en5) begin
      dn_valid <= s4_valid;
    end
    if (en5) begin
      dn_ctrl  <= s4_ctrl;
      flow_fwd <= sum_f[SB+9:8];
      flow_bwd <= sum_b[SB+9:8];
      dn_half  <= s4_half;
    end
  end

endmodule

/* rtl/core/mfb_out.sv */
`timescale 1ns / 1ps
// back of the blend pipe: time weighting, half-time select, clamp, output register
// stages 6 and 7; depends on mfb_pkg

module mfb_out #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  mfb_pkg::ctrl_t            up_ctrl,
  input  logic [SAMPLE_BITS+1:0]    flow_fwd,
  input  logic [SAMPLE_BITS+1:0]    flow_bwd,
  input  logic [SAMPLE_BITS:0]      half_res,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [mfb_pkg::OUT_W-1:0] blended_pixel
);
  import mfb_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic en6, en7;

  logic           s6_valid;
  ctrl_t          s6_ctrl;
  logic [SB+10:0] s6_wf, s6_wb;
  logic [SB:0]    s6_half;

  logic [SB+11:0] wsum;
  logic [SB+3:0]  res, limit, clamped;

  assign en7      = !dn_valid || dn_ready;
  assign en6      = !s6_valid || en7;
  assign up_ready = en6;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en6) begin
      s6_valid <= up_valid;
    end
    if (en6) begin
      s6_ctrl <= up_ctrl;
      s6_wf   <= (SB+11)'(flow_fwd) * (SB+11)'(TW_MAX - up_ctrl.tw);
      s6_wb   <= (SB+11)'(flow_bwd) * (SB+11)'(up_ctrl.tw);
      s6_half <= half_res;
    end
  end

  assign wsum    = (SB+12)'(s6_wf) + (SB+12)'(s6_wb);
  assign res     = s6_ctrl.half ? (SB+4)'(s6_half) : wsum[SB+11:8];
  assign limit   = s6_ctrl.wide ? (SB+4)'({SB{1'b1}}) : (SB+4)'(NARROW_MAX);
  assign clamped = (res > limit) ? limit : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en7) begin
      dn_valid <= s6_valid;
    end
    if (en7) begin
      blended_pixel <= OUT_W'(clamped[SB-1:0]);
    end
  end

endmodule

/* rtl/core/mfb_check.sv */
`timescale 1ns / 1ps
// port-level checks for the frame blend: output hold, back-pressure, item count
// depends on mfb_pkg; bound onto motion_flow_frame_blend below

module mfb_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          pix_valid,
  input logic                          pix_ready,
  input logic                          blend_valid,
  input logic                          blend_ready,
  input logic [mfb_pkg::OUT_W-1:0]     blended_pixel,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [mfb_pkg::CFG_IDX_W-1:0] cfg_index
);
  import mfb_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH) + 1;

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;
  logic             in_xfer, out_xfer;

  assign in_xfer  = pix_valid && pix_ready;
  assign out_xfer = blend_valid && blend_ready;

  always_comb begin
    inflight_next = inflight;
    if (in_xfer && !out_xfer) begin
      inflight_next = inflight + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      inflight_next = inflight - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    blend_valid && !blend_ready |=> blend_valid && $stable(blended_pixel))
    else $error("stalled output changed or dropped");

  // input only back-pressured when the output itself is stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> blend_valid && !blend_ready)
    else $error("input stalled while output free");

  // no result without a pixel in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    blend_valid |-> inflight != '0)
    else $error("output without matching input");

  // occupancy bounded by the stage count
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than stages");

  // configuration port never back-pressures, whatever register is addressed
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled on index %0d", cfg_index);

endmodule

bind motion_flow_frame_blend mfb_check u_mfb_check (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pix_valid),
  .pix_ready    (pix_ready),
  .blend_valid  (blend_valid),
  .blend_ready  (blend_ready),
  .blended_pixel(blended_pixel),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_index    (cfg_index)
);
